FILE: hdl/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
// Each macro expands to one labeled concurrent assertion on clk,
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/erp_pkg.sv
// ----------------------------------------------------------------------------
// erp_pkg
// Action codes and controller states for the byte-wide rotor.
// ----------------------------------------------------------------------------
`default_nettype none

package erp_pkg;

    typedef enum logic [2:0] {
        ACT_LOAD     = 3'd0,
        ACT_FWD      = 3'd1,
        ACT_BWD      = 3'd2,
        ACT_ROTATE   = 3'd3,
        ACT_SET_NULL = 3'd4,
        ACT_DROP     = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FWD,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/enigma_rotor_permutation_top.sv
// ----------------------------------------------------------------------------
// enigma_rotor_permutation_top
// Byte-wide rotor: loadable 256-entry wiring table in a synchronous RAM,
// rotor and null position registers, forward and backward mapping.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | action, entry_index, symbol_in,
//           |                      | step_distance
//   out     | out_valid/ out_ready | symbol_out, at_null
//
// Load, rotate, set null, drop and unused codes finish in the transfer cycle.
// Forward does one registered read of the wiring RAM and finishes in ST_FWD.
// Backward uses the single RAM read port to scan one entry a cycle from
// index 0 until the first match, or through all 256 entries.
// A result that finds the output register occupied is parked in ST_DONE.
// Reset clears positions and control; the table needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module enigma_rotor_permutation_top
    import erp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] action,
    input  wire logic [7:0] entry_index,
    input  wire logic [7:0] symbol_in,
    input  wire logic [7:0] step_distance,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      symbol_out,
    output logic            at_null
);

    // Wiring table RAM
    logic [7:0] table_mem [256];
    logic       mem_we;
    logic [7:0] mem_raddr;
    logic [7:0] rd_data_reg;

    state_t     state_reg, state_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] null_reg, null_next;
    logic [7:0] scan_reg, scan_next;
    logic [7:0] rel_reg;
    logic [7:0] hold_sym_reg;
    logic       hold_null_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_sym_reg;
    logic       out_null_reg;

    logic       in_xfer;
    logic [7:0] rel;
    logic       fin;
    logic [7:0] fin_sym;
    logic       fin_null;
    logic       out_free;
    logic       out_load;
    logic       hold_load;
    logic [7:0] out_sym_d;
    logic       out_null_d;

    assign in_xfer  = in_valid && in_ready;
    assign rel      = symbol_in - pos_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[entry_index] <= symbol_in;
        end
        rd_data_reg <= table_mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        null_next  = null_reg;
        scan_next  = scan_reg;
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        mem_raddr  = 8'd0;
        fin        = 1'b0;
        fin_sym    = 8'd0;
        out_load   = 1'b0;
        hold_load  = 1'b0;
        out_sym_d  = hold_sym_reg;
        out_null_d = hold_null_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (action_t'(action))
                        ACT_LOAD:
                        begin
                            mem_we = 1'b1;
                            fin    = 1'b1;
                        end
                        ACT_FWD:
                        begin
                            mem_raddr  = rel;
                            state_next = ST_FWD;
                        end
                        ACT_BWD:
                        begin
                            mem_raddr  = 8'd0;
                            scan_next  = 8'd0;
                            state_next = ST_SCAN;
                        end
                        ACT_ROTATE:
                        begin
                            pos_next = pos_reg + step_distance;
                            fin      = 1'b1;
                        end
                        ACT_SET_NULL:
                        begin
                            null_next = pos_reg;
                            fin       = 1'b1;
                        end
                        ACT_DROP:
                        begin
                            pos_next  = 8'd0;
                            null_next = 8'd0;
                            fin       = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_FWD:
            begin
                fin     = 1'b1;
                fin_sym = rd_data_reg + pos_reg;
            end
            ST_SCAN:
            begin
                if (rd_data_reg == rel_reg)
                begin
                    fin     = 1'b1;
                    fin_sym = scan_reg + pos_reg;
                end
                else if (scan_reg == 8'hFF)
                begin
                    // no entry holds the value: relative result wraps to 0
                    fin     = 1'b1;
                    fin_sym = pos_reg;
                end
                else
                begin
                    scan_next = scan_reg + 8'd1;
                    mem_raddr = scan_reg + 8'd1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        fin_null = (pos_next == null_next);
        if (fin)
        begin
            out_sym_d  = fin_sym;
            out_null_d = fin_null;
            if (out_free)
            begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            else
            begin
                // output still occupied: park the result
                hold_load  = 1'b1;
                state_next = ST_DONE;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= 8'd0;
            null_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            null_reg      <= null_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (in_xfer)
        begin
            rel_reg <= rel;
        end
        if (hold_load)
        begin
            hold_sym_reg  <= fin_sym;
            hold_null_reg <= fin_null;
        end
        if (out_load)
        begin
            out_sym_reg  <= out_sym_d;
            out_null_reg <= out_null_d;
        end
    end

    assign out_valid  = out_valid_reg;
    assign symbol_out = out_sym_reg;
    assign at_null    = out_null_reg;

    `ASSERT_NEXT(a_scan_step, (state_reg == ST_SCAN) && (state_next == ST_SCAN),
        scan_reg == 8'($past(scan_reg) + 8'd1), "scan index skipped an entry")

    `ASSERT_ALWAYS(a_done_out_busy, (state_reg != ST_DONE) || out_valid_reg,
        "parked result while output register empty")

    `ASSERT_NEXT(a_pos_stable, !in_xfer, $stable(pos_reg) && $stable(null_reg),
        "position changed without an input transfer")

endmodule

`default_nettype wire
